// ===== hdl/delta_clock_timer_queue_unit_macros.svh =====
// Assertion macros shared by the timer queue RTL.
`ifndef DELTA_CLOCK_TIMER_QUEUE_UNIT_MACROS_SVH
`define DELTA_CLOCK_TIMER_QUEUE_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DCTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define DCTQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/dctq_pkg.sv =====
// Package with the constants, codes and types of the delta-clock timer queue.
`default_nettype none

package dctq_pkg;

  localparam int QueueDepth = 16;
  localparam int BurstMax   = 16;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int BurstW     = $clog2(BurstMax + 1);
  localparam int DeltaW     = 16;
  localparam int IdW        = 8;
  localparam int KindW      = 2;

  localparam logic [KindW-1:0] KindAccept = 2'd0;
  localparam logic [KindW-1:0] KindFull   = 2'd1;
  localparam logic [KindW-1:0] KindFired  = 2'd2;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeTick   = 1'b1;

  typedef enum logic [1:0] {
    StoreNone,
    StoreInsert,
    StorePop,
    StoreHead
  } store_op_e;

  typedef struct packed {
    store_op_e         op;
    logic [PtrW-1:0]   pos;
    logic [DeltaW-1:0] new_delta;
    logic [IdW-1:0]    new_id;
    logic              split_en;
    logic [DeltaW-1:0] split_delta;
  } store_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dctq_store.sv =====
// Entry store of the timer queue: ordered delta and event registers with shift moves.
`default_nettype none

module dctq_store
  import dctq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire store_ctrl_t       ctrl_i,
  input  wire logic [PtrW-1:0]   rd_pos_i,
  output logic      [DeltaW-1:0] rd_delta_o,
  output logic      [DeltaW-1:0] head_delta_o,
  output logic      [IdW-1:0]    head_id_o,
  output logic      [DeltaW-1:0] next_delta_o
);

  logic [DeltaW-1:0] delta_q [QueueDepth];
  logic [IdW-1:0]    event_q [QueueDepth];
  logic [DeltaW-1:0] below_delta [QueueDepth];
  logic [IdW-1:0]    below_id    [QueueDepth];
  logic [DeltaW-1:0] above_delta [QueueDepth];
  logic [IdW-1:0]    above_id    [QueueDepth];
  logic [CntW-1:0]   split_pos;

  assign split_pos = {{(CntW-PtrW){1'b0}}, ctrl_i.pos} + CntW'(1);

  for (genvar j = 0; j < QueueDepth; j++) begin : g_entry
    if (j == 0) begin : g_first
      assign below_delta[j] = delta_q[j];
      assign below_id[j]    = event_q[j];
    end else begin : g_rest
      assign below_delta[j] = delta_q[j-1];
      assign below_id[j]    = event_q[j-1];
    end
    if (j == QueueDepth - 1) begin : g_last
      assign above_delta[j] = delta_q[j];
      assign above_id[j]    = event_q[j];
    end else begin : g_inner
      assign above_delta[j] = delta_q[j+1];
      assign above_id[j]    = event_q[j+1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QueueDepth; j++) begin
      case (ctrl_i.op)
        StoreInsert: begin
          if (ctrl_i.split_en && (split_pos == CntW'(j))) begin
            delta_q[j] <= ctrl_i.split_delta;
            event_q[j] <= below_id[j];
          end else if (PtrW'(j) == ctrl_i.pos) begin
            delta_q[j] <= ctrl_i.new_delta;
            event_q[j] <= ctrl_i.new_id;
          end else if (PtrW'(j) > ctrl_i.pos) begin
            delta_q[j] <= below_delta[j];
            event_q[j] <= below_id[j];
          end
        end
        StorePop: begin
          delta_q[j] <= above_delta[j];
          event_q[j] <= above_id[j];
        end
        StoreHead: begin
          if (j == 0) begin
            delta_q[j] <= ctrl_i.new_delta;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_delta_o   = delta_q[rd_pos_i];
  assign head_delta_o = delta_q[0];
  assign head_id_o    = event_q[0];
  assign next_delta_o = above_delta[0];

endmodule

`default_nettype wire

// ===== hdl/delta_clock_timer_queue_unit.sv =====
// Delta-clock timer queue: one shared subtractor under a small sequencer.
// An insert walks the subtractor over the stored entries (up to 15), then places the entry.
// A rejected insert is answered without a walk; a tick on an empty queue gives no result; any
// other tick decrements the head and pops its fired events; a result held by the receiver adds its wait.
// One transaction is in work at a time; results wait in an output register.
// Reset empties the queue; stored deltas and ids are undefined until written.
`default_nettype none

`include "delta_clock_timer_queue_unit_macros.svh"

module delta_clock_timer_queue_unit
  import dctq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // delay [15:0], event_id [23:16]
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,  // fired_event [7:0]
  output logic      [1:0]  m_axis_tuser,  // kind
  output logic             m_axis_tlast
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StWalk    = 3'd1;
  localparam logic [2:0] StPlace   = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StTickDec = 3'd4;
  localparam logic [2:0] StFire    = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [DeltaW-1:0] rem_q, rem_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [BurstW-1:0] burst_q, burst_d;
  logic              out_valid_q;
  logic [KindW-1:0]  out_kind_q;
  logic [IdW-1:0]    out_id_q;
  logic              out_last_q;

  logic              emit;
  logic [KindW-1:0]  emit_kind;
  logic [IdW-1:0]    emit_id;
  logic              emit_last;
  logic              out_free;
  logic              in_fire;

  logic [DeltaW-1:0] sub_a, sub_b;
  logic [DeltaW:0]   sub_res;
  logic              sub_borrow;

  store_ctrl_t       ctrl;
  logic [DeltaW-1:0] rd_delta, head_delta, next_delta;
  logic [IdW-1:0]    head_id;

  logic [DeltaW-1:0] in_delay;
  logic [IdW-1:0]    in_id;

  assign in_delay      = s_axis_tdata[15:0];
  assign in_id         = s_axis_tdata[23:16];
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[DeltaW];

  dctq_store u_store (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .rd_pos_i     (pos_q[PtrW-1:0]),
    .rd_delta_o   (rd_delta),
    .head_delta_o (head_delta),
    .head_id_o    (head_id),
    .next_delta_o (next_delta)
  );

  always_comb begin
    sub_a = rem_q;
    sub_b = rd_delta;
    case (state_q)
      StPlace: begin
        sub_a = rd_delta;
        sub_b = rem_q;
      end
      StTickDec: begin
        sub_a = head_delta;
        sub_b = DeltaW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    pos_d            = pos_q;
    rem_d            = rem_q;
    id_d             = id_q;
    burst_d          = burst_q;
    emit             = 1'b0;
    emit_kind        = KindAccept;
    emit_id          = id_q;
    emit_last        = 1'b1;
    ctrl.op          = StoreNone;
    ctrl.pos         = pos_q[PtrW-1:0];
    ctrl.new_delta   = rem_q;
    ctrl.new_id      = id_q;
    ctrl.split_en    = 1'b0;
    ctrl.split_delta = sub_res[DeltaW-1:0];
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          pos_d = '0;
          rem_d = (in_delay == '0) ? DeltaW'(1) : in_delay;
          id_d  = in_id;
          if (s_axis_tuser == ModeTick) begin
            if (count_q != '0) begin
              state_d = StTickDec;
            end
          end else if (count_q == CntW'(QueueDepth)) begin
            state_d = StFull;
          end else begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if ((pos_q < count_q) && !sub_borrow) begin
          rem_d = sub_res[DeltaW-1:0];
          pos_d = pos_q + CntW'(1);
        end else begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        if (out_free) begin
          ctrl.op       = StoreInsert;
          ctrl.split_en = (pos_q < count_q);
          count_d       = count_q + CntW'(1);
          emit          = 1'b1;
          emit_kind     = KindAccept;
          state_d       = StIdle;
        end
      end
      StFull: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KindFull;
          state_d   = StIdle;
        end
      end
      StTickDec: begin
        if (!sub_borrow) begin
          ctrl.op        = StoreHead;
          ctrl.new_delta = sub_res[DeltaW-1:0];
        end
        burst_d = '0;
        state_d = StFire;
      end
      StFire: begin
        if ((count_q != '0) && (head_delta == '0) && (burst_q < BurstW'(BurstMax))) begin
          if (out_free) begin
            ctrl.op   = StorePop;
            emit      = 1'b1;
            emit_kind = KindFired;
            emit_id   = head_id;
            emit_last = (count_q == CntW'(1)) || (next_delta != '0) ||
                        (burst_q + BurstW'(1) == BurstW'(BurstMax));
            count_d   = count_q - CntW'(1);
            burst_d   = burst_q + BurstW'(1);
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      pos_q       <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      burst_q <= burst_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    id_q  <= id_d;
    if (emit) begin
      out_kind_q <= emit_kind;
      out_id_q   <= emit_id;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  `DCTQ_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth), "Entry count exceeds the queue depth.")
  `DCTQ_ASSERT(a_walk_room, (state_q == StWalk) |-> (count_q < CntW'(QueueDepth)), "Walk on a full queue.")
  `DCTQ_ASSERT(a_walk_pos, (state_q == StWalk) |-> (pos_q <= count_q), "Walk position beyond the entry count.")
  `DCTQ_ASSERT_NEVER(a_emit_busy, emit && out_valid_q && !m_axis_tready, "Result overwrites a pending transaction.")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking stream testbench for the delta-clock timer queue unit.
module tb;
  import dctq_pkg::*;

  localparam int RandomItems = 380;
  localparam int CycleLimit  = 200000;
  localparam int TailCycles  = 60;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   id;
    logic             last;
  } tq_result_t;

  typedef struct packed {
    logic              mode;
    logic [DeltaW-1:0] delay;
    logic [IdW-1:0]    id;
    logic [4:0]        rep;
    logic              typed;
    logic [4:0]        n_typed;
    logic [KindW-1:0]  kind;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [DeltaW-1:0] queue_delta [QueueDepth];
  logic [IdW-1:0]    queue_event [QueueDepth];
  int                queue_count = 0;
  tq_result_t        step_results [$];
  tq_result_t        awaited [$];
  tq_result_t        want;

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          rand_sent = 0;
  logic [1:0]  stall_mode = 2'd0;
  logic [7:0]  rx_phase = '0;

  // For typed rows the expected id is the row id plus the repeat index; a tick
  // row that fires carries the expected event id in its id column.
  dir_row_t dir_rows [14] = '{
    '{ModeTick,   16'd0,     8'h00, 5'd1,  1'b1, 5'd0, KindAccept},
    '{ModeInsert, 16'd0,     8'hAA, 5'd1,  1'b1, 5'd1, KindAccept},
    '{ModeTick,   16'd0,     8'hAA, 5'd1,  1'b1, 5'd1, KindFired},
    '{ModeTick,   16'd0,     8'h00, 5'd1,  1'b1, 5'd0, KindAccept},
    '{ModeInsert, 16'hFFFF,  8'hFF, 5'd1,  1'b1, 5'd1, KindAccept},
    '{ModeInsert, 16'd5,     8'h01, 5'd1,  1'b1, 5'd1, KindAccept},
    '{ModeInsert, 16'd5,     8'h02, 5'd1,  1'b1, 5'd1, KindAccept},
    '{ModeInsert, 16'd3,     8'h03, 5'd1,  1'b1, 5'd1, KindAccept},
    '{ModeInsert, 16'd3,     8'h10, 5'd12, 1'b1, 5'd1, KindAccept},
    '{ModeInsert, 16'd1,     8'h55, 5'd1,  1'b1, 5'd1, KindFull},
    '{ModeTick,   16'd0,     8'h00, 5'd2,  1'b0, 5'd0, KindAccept},
    '{ModeTick,   16'd0,     8'h00, 5'd1,  1'b0, 5'd0, KindAccept},
    '{ModeTick,   16'd0,     8'h00, 5'd2,  1'b0, 5'd0, KindAccept},
    '{ModeInsert, 16'd0,     8'h00, 5'd1,  1'b1, 5'd1, KindAccept}
  };

  delta_clock_timer_queue_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void advance_timer_queue(input logic mode, input logic [DeltaW-1:0] delay,
                                              input logic [IdW-1:0] id);
    logic [DeltaW-1:0] rem;
    int                pos;
    int                n;
    tq_result_t        r;
    step_results.delete();
    if (mode == ModeInsert) begin
      rem = (delay == '0) ? DeltaW'(1) : delay;
      if (queue_count >= QueueDepth) begin
        r = '{KindFull, id, 1'b1};
        step_results.push_back(r);
      end else begin
        pos = 0;
        while (pos < queue_count && rem >= queue_delta[pos]) begin
          rem = rem - queue_delta[pos];
          pos++;
        end
        for (int j = queue_count; j > pos; j--) begin
          queue_delta[j] = queue_delta[j-1];
          queue_event[j] = queue_event[j-1];
        end
        queue_delta[pos] = rem;
        queue_event[pos] = id;
        if (pos < queue_count) queue_delta[pos+1] = queue_delta[pos+1] - rem;
        queue_count++;
        r = '{KindAccept, id, 1'b1};
        step_results.push_back(r);
      end
    end else if (queue_count > 0) begin
      if (queue_delta[0] > 0) queue_delta[0] = queue_delta[0] - 1'b1;
      n = 0;
      while (queue_count > 0 && queue_delta[0] == '0 && n < BurstMax) begin
        r = '{KindFired, queue_event[0], 1'b0};
        step_results.push_back(r);
        n++;
        for (int j = 1; j < queue_count; j++) begin
          queue_delta[j-1] = queue_delta[j];
          queue_event[j-1] = queue_event[j];
        end
        queue_count--;
      end
      if (n > 0) begin
        r = step_results[n-1];
        r.last = 1'b1;
        step_results[n-1] = r;
      end
    end
  endfunction

  task automatic send_item(input logic mode, input logic [DeltaW-1:0] delay,
                           input logic [IdW-1:0] id);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {id, delay};
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic issue(input logic mode, input logic [DeltaW-1:0] delay,
                       input logic [IdW-1:0] id);
    send_item(mode, delay, id);
    advance_timer_queue(mode, delay, id);
    foreach (step_results[k]) awaited.push_back(step_results[k]);
    rand_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DeltaW-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 199);
    if (queue_count == QueueDepth) return DeltaW'($urandom_range(0, 65535));
    if (r < 20) return '0;
    if (r < 21) return DeltaW'($urandom_range(0, 65535));
    if (r < 160) return DeltaW'($urandom_range(1, 6));
    return DeltaW'($urandom_range(7, 40));
  endfunction

  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase[5:0] == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= rx_phase[2];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: kind %0d id %02h last %0b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = awaited.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata !== want.id ||
            m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind %0d id %02h last %0b, got kind %0d id %02h last %0b",
                     want.kind, want.id, want.last, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    logic [7:0] item_id;
    tq_result_t r;
    int         len;
    int         d;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      for (int k = 0; k < row.rep; k++) begin
        item_id = row.id + 8'(k);
        send_item(row.mode, row.delay, item_id);
        advance_timer_queue(row.mode, row.delay, item_id);
        if (row.typed) begin
          for (int n = 0; n < row.n_typed; n++) begin
            r = '{row.kind, item_id, (n == row.n_typed - 1)};
            awaited.push_back(r);
          end
        end else begin
          foreach (step_results[n]) awaited.push_back(step_results[n]);
        end
      end
    end
    wait_drained();

    rand_sent = 0;
    while (rand_sent < RandomItems) begin
      if ($urandom_range(0, 3) == 0) begin
        // Fill with one common expiry, sometimes past full, then tick it out.
        d = $urandom_range(0, 4);
        len = $urandom_range(1, QueueDepth - queue_count + 1);
        repeat (len) issue(ModeInsert, DeltaW'(d), IdW'($urandom));
        repeat (((d == 0) ? 1 : d) + $urandom_range(0, 1))
          issue(ModeTick, DeltaW'($urandom), IdW'($urandom));
      end else begin
        len = $urandom_range(8, 24);
        repeat (len) begin
          if ($urandom_range(0, 99) < 45) issue(ModeTick, DeltaW'($urandom), IdW'($urandom));
          else issue(ModeInsert, pick_delay(), IdW'($urandom));
        end
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
